// ----- hw/rtl/fcfe_pkg.sv -----
// Shared types, constants and helper functions for the cube face emitter.
package fcfe_pkg;

  localparam int MAX_LEVEL = 4;
  localparam int FRAC_BITS = 8;

  localparam int CELL_W    = 7;
  localparam int NBR_W     = CELL_W + 1;
  localparam int LVL_W     = 3;
  localparam int SIZE_W    = 24;
  localparam int POS_W     = 25;
  localparam int UV_W      = 17;
  localparam int FACE_W    = 3;
  localparam int CNT_W     = 22;
  localparam int GRID_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W     = NBR_W + SIZE_W;
  localparam int P2_W      = MUL_W + 2;
  localparam int DIV_W     = SIZE_W + 1;
  localparam int NUM_W     = DIV_W + UV_W;

  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  // multiply-shift for exact division by 3 on 8-bit values
  localparam int DIV3_MUL   = 171;
  localparam int DIV3_SHIFT = 9;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPONGE_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 2'd2;

  localparam logic [LVL_W-1:0]  LEVEL_RESET  = 3'd3;
  localparam logic [SIZE_W-1:0] SPONGE_RESET = 24'd25600;
  localparam logic [SIZE_W-1:0] CELL_RESET   = 24'd948;

  localparam int NUM_FACES = 6;
  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

  localparam logic [1:0] VTX_LAST = 2'd3;

  localparam longint POS_LIM_I = longint'(1) << (FRAC_BITS + 15);
  localparam logic signed [P2_W-1:0] POS_LIM = P2_W'(POS_LIM_I);
  localparam logic signed [P2_W-1:0] NEG_LIM = P2_W'(-POS_LIM_I);
  localparam logic [UV_W-1:0] UV_ONE = 17'h10000;

  typedef logic [NUM_FACES-1:0] face_mask_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    face_mask_t        faces;
    logic              new_mesh;
  } cell_entry_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    logic [FACE_W-1:0] face;
    logic [1:0]        corner_idx;
    logic [CNT_W-1:0]  vnum;
    logic              last;
  } vtx_job_t;

  // corner code: bit0 x high, bit1 y high, bit2 z high
  function automatic logic [2:0] corner_code(logic [FACE_W-1:0] face, logic [1:0] idx);
    logic [11:0] row;
    case (face)
      FACE_PX: row = {3'd7, 3'd5, 3'd1, 3'd3};
      FACE_NX: row = {3'd4, 3'd6, 3'd2, 3'd0};
      FACE_PY: row = {3'd6, 3'd7, 3'd3, 3'd2};
      FACE_NY: row = {3'd5, 3'd4, 3'd0, 3'd1};
      FACE_PZ: row = {3'd5, 3'd7, 3'd6, 3'd4};
      FACE_NZ: row = {3'd0, 3'd2, 3'd3, 3'd1};
      default: row = '0;
    endcase
    return row[idx*3 +: 3];
  endfunction

  // one flag per base-3 digit: digit equals 1
  function automatic logic [MAX_LEVEL-1:0] mid_digits(logic [NBR_W-1:0] val);
    logic [NBR_W-1:0]   v;
    logic [NBR_W-1:0]   q;
    logic [NBR_W-1:0]   r;
    logic [2*NBR_W-1:0] prod;
    logic [MAX_LEVEL-1:0] m;
    v = val;
    m = '0;
    for (int i = 0; i < MAX_LEVEL; i++) begin
      prod = (2*NBR_W)'(v) * (2*NBR_W)'(DIV3_MUL);
      q    = NBR_W'(prod >> DIV3_SHIFT);
      r    = v - (q + {q[NBR_W-2:0], 1'b0});
      m[i] = (r == NBR_W'(1));
      v    = q;
    end
    return m;
  endfunction

  function automatic logic [GRID_W-1:0] grid_side(logic [LVL_W-1:0] lv);
    logic [GRID_W-1:0] g;
    g = GRID_W'(1);
    for (int i = 0; i < MAX_LEVEL; i++) begin
      if (LVL_W'(i) < lv) g = g + {g[GRID_W-2:0], 1'b0};
    end
    return g;
  endfunction

  function automatic logic [MAX_LEVEL-1:0] level_mask(logic [LVL_W-1:0] lv);
    logic [MAX_LEVEL-1:0] m;
    for (int i = 0; i < MAX_LEVEL; i++) m[i] = (LVL_W'(i) < lv);
    return m;
  endfunction

  // solid unless two or more coordinates have a middle digit at the same active level
  function automatic logic cell_solid(logic [MAX_LEVEL-1:0] mx, logic [MAX_LEVEL-1:0] my,
                                      logic [MAX_LEVEL-1:0] mz, logic [MAX_LEVEL-1:0] lmask);
    return (((mx & my) | (my & mz) | (mx & mz)) & lmask) == '0;
  endfunction

endpackage

// ----- hw/rtl/fractal_cube_face_emitter_unit.sv -----
// Top level of the cube face emitter: configuration registers and block wiring.
//
// Input channel: one cell index (x, y, z) and a new_mesh flag per item, taken when
// in_push is high and in_full is low. Items enter a four-deep cell queue at up to one
// per cycle; cells with no exposed face (off the grid, hollow or enclosed) that do not
// restart the count are dropped at the door.
// Result channel: one vertex per item, shown while out_empty is low and taken with
// out_pop. Each exposed face of a solid cell gives four vertices, up to 24 per
// cell; a kept cell with no faces (count restart only) gives no vertex but takes a
// turn at the sequencer. The sequencer and the vertex pipeline run one vertex per
// cycle back to back across cells while the output is not held and cells are queued.
// Path from accept to the first vertex: queue, sequencer, the position multiply
// stage, the rounding stage, 17 UV divider stages (one quotient bit each), and the
// output register.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 level_count, 1 sponge_size,
// 2 cell_size; other indexes are ignored. cfg_ready is always high. Write only
// while no cell is in flight.
// Reset clears the queue, the pipeline and the vertex counter and loads the
// default register values. While a vertex is shown and out_pop stays low the whole
// vertex pipeline holds; the cell queue keeps accepting until it fills.
module fractal_cube_face_emitter_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [fcfe_pkg::CELL_W-1:0]           in_cell_x,
  input  logic [fcfe_pkg::CELL_W-1:0]           in_cell_y,
  input  logic [fcfe_pkg::CELL_W-1:0]           in_cell_z,
  input  logic                                  in_new_mesh,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [fcfe_pkg::POS_W-1:0]     out_pos_x,
  output logic signed [fcfe_pkg::POS_W-1:0]     out_pos_y,
  output logic signed [fcfe_pkg::POS_W-1:0]     out_pos_z,
  output logic [fcfe_pkg::UV_W-1:0]             out_tex_u,
  output logic [fcfe_pkg::UV_W-1:0]             out_tex_v,
  output logic [fcfe_pkg::FACE_W-1:0]           out_face_dir,
  output logic [fcfe_pkg::CNT_W-1:0]            out_vertex_number,
  output logic                                  out_last_vertex,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fcfe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fcfe_pkg::SIZE_W-1:0]           cfg_data
);

  logic [fcfe_pkg::LVL_W-1:0]  level_count_r;
  logic [fcfe_pkg::SIZE_W-1:0] sponge_size_r;
  logic [fcfe_pkg::SIZE_W-1:0] cell_size_r;

  logic                        accept;
  logic                        q_push, q_full, q_pop, q_empty;
  fcfe_pkg::cell_entry_t       q_wr_entry, q_rd_entry;
  logic                        job_valid, adv;
  fcfe_pkg::vtx_job_t          job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= fcfe_pkg::LEVEL_RESET;
      sponge_size_r <= fcfe_pkg::SPONGE_RESET;
      cell_size_r   <= fcfe_pkg::CELL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fcfe_pkg::REG_LEVEL_COUNT: level_count_r <= cfg_data[fcfe_pkg::LVL_W-1:0];
        fcfe_pkg::REG_SPONGE_SIZE: sponge_size_r <= cfg_data;
        fcfe_pkg::REG_CELL_SIZE:   cell_size_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  fcfe_front u_front (
    .accept      (accept),
    .cell_x      (in_cell_x),
    .cell_y      (in_cell_y),
    .cell_z      (in_cell_z),
    .new_mesh    (in_new_mesh),
    .level_count (level_count_r),
    .q_push      (q_push),
    .q_entry     (q_wr_entry)
  );

  fcfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .empty    (q_empty)
  );

  fcfe_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .q_empty   (q_empty),
    .q_entry   (q_rd_entry),
    .q_pop     (q_pop),
    .job_valid (job_valid),
    .job       (job)
  );

  fcfe_vtx u_vtx (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (job_valid),
    .job               (job),
    .sponge_size       (sponge_size_r),
    .cell_size         (cell_size_r),
    .adv               (adv),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pos_z         (out_pos_z),
    .out_tex_u         (out_tex_u),
    .out_tex_v         (out_tex_v),
    .out_face_dir      (out_face_dir),
    .out_vertex_number (out_vertex_number),
    .out_last_vertex   (out_last_vertex)
  );

endmodule

// ----- hw/rtl/fcfe_front.sv -----
// Front end: classifies an incoming cell and works out its exposed faces.
module fcfe_front (
  input  logic                                 accept,
  input  logic [fcfe_pkg::CELL_W-1:0]          cell_x,
  input  logic [fcfe_pkg::CELL_W-1:0]          cell_y,
  input  logic [fcfe_pkg::CELL_W-1:0]          cell_z,
  input  logic                                 new_mesh,
  input  logic [fcfe_pkg::LVL_W-1:0]           level_count,
  output logic                                 q_push,
  output fcfe_pkg::cell_entry_t                q_entry
);

  logic [fcfe_pkg::LVL_W-1:0]     lv;
  logic [fcfe_pkg::GRID_W-1:0]    grid;
  logic [fcfe_pkg::MAX_LEVEL-1:0] lmask;
  logic [fcfe_pkg::NBR_W-1:0]     x0, y0, z0, xp, yp, zp, xm, ym, zm;
  logic [fcfe_pkg::MAX_LEVEL-1:0] mx, my, mz, mxp, myp, mzp, mxm, mym, mzm;
  logic                           in_grid, solid;
  fcfe_pkg::face_mask_t           exposed, faces;

  assign lv = (level_count > fcfe_pkg::LVL_W'(fcfe_pkg::MAX_LEVEL)) ?
              fcfe_pkg::LVL_W'(fcfe_pkg::MAX_LEVEL) : level_count;
  assign grid  = fcfe_pkg::grid_side(lv);
  assign lmask = fcfe_pkg::level_mask(lv);

  assign x0 = fcfe_pkg::NBR_W'(cell_x);
  assign y0 = fcfe_pkg::NBR_W'(cell_y);
  assign z0 = fcfe_pkg::NBR_W'(cell_z);
  assign xp = x0 + 1'b1;
  assign yp = y0 + 1'b1;
  assign zp = z0 + 1'b1;
  assign xm = x0 - 1'b1;
  assign ym = y0 - 1'b1;
  assign zm = z0 - 1'b1;

  assign mx  = fcfe_pkg::mid_digits(x0);
  assign my  = fcfe_pkg::mid_digits(y0);
  assign mz  = fcfe_pkg::mid_digits(z0);
  assign mxp = fcfe_pkg::mid_digits(xp);
  assign myp = fcfe_pkg::mid_digits(yp);
  assign mzp = fcfe_pkg::mid_digits(zp);
  assign mxm = fcfe_pkg::mid_digits(xm);
  assign mym = fcfe_pkg::mid_digits(ym);
  assign mzm = fcfe_pkg::mid_digits(zm);

  assign in_grid = (fcfe_pkg::GRID_W'(x0) < grid) && (fcfe_pkg::GRID_W'(y0) < grid) &&
                   (fcfe_pkg::GRID_W'(z0) < grid);
  assign solid   = fcfe_pkg::cell_solid(mx, my, mz, lmask);

  // a face is exposed when its neighbor is off the grid or hollow
  always_comb begin
    exposed = '0;
    exposed[fcfe_pkg::FACE_PX] = (fcfe_pkg::GRID_W'(xp) >= grid) ||
                                 !fcfe_pkg::cell_solid(mxp, my, mz, lmask);
    exposed[fcfe_pkg::FACE_NX] = (cell_x == '0) || !fcfe_pkg::cell_solid(mxm, my, mz, lmask);
    exposed[fcfe_pkg::FACE_PY] = (fcfe_pkg::GRID_W'(yp) >= grid) ||
                                 !fcfe_pkg::cell_solid(mx, myp, mz, lmask);
    exposed[fcfe_pkg::FACE_NY] = (cell_y == '0) || !fcfe_pkg::cell_solid(mx, mym, mz, lmask);
    exposed[fcfe_pkg::FACE_PZ] = (fcfe_pkg::GRID_W'(zp) >= grid) ||
                                 !fcfe_pkg::cell_solid(mx, my, mzp, lmask);
    exposed[fcfe_pkg::FACE_NZ] = (cell_z == '0) || !fcfe_pkg::cell_solid(mx, my, mzm, lmask);
  end

  assign faces = (in_grid && solid) ? exposed : '0;

  // items with nothing to emit only matter when they restart the count
  assign q_push = accept && ((faces != '0) || new_mesh);
  assign q_entry = '{cell_x: cell_x, cell_y: cell_y, cell_z: cell_z,
                     faces: faces, new_mesh: new_mesh};

endmodule

// ----- hw/rtl/fcfe_queue.sv -----
// Small cell queue between the front end and the vertex sequencer.
module fcfe_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fcfe_pkg::cell_entry_t wr_entry,
  output logic                  full,
  input  logic                  pop,
  output fcfe_pkg::cell_entry_t rd_entry,
  output logic                  empty
);

  fcfe_pkg::cell_entry_t             mem_r [fcfe_pkg::Q_DEPTH];
  logic [fcfe_pkg::Q_PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [fcfe_pkg::Q_CNT_W-1:0]      count_r;
  logic                              do_push, do_pop;

  assign full     = (count_r == fcfe_pkg::Q_CNT_W'(fcfe_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (!do_push && do_pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_entry;
  end

endmodule

// ----- hw/rtl/fcfe_seq.sv -----
// Vertex sequencer: walks the exposed faces of a queued cell, one vertex a cycle unless adv is low.
module fcfe_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  q_empty,
  input  fcfe_pkg::cell_entry_t q_entry,
  output logic                  q_pop,
  output logic                  job_valid,
  output fcfe_pkg::vtx_job_t    job
);

  logic                           cur_vld_r, cur_vld_nxt;
  logic [fcfe_pkg::CELL_W-1:0]    cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  fcfe_pkg::face_mask_t           mask_r, mask_nxt, mask_left;
  logic [1:0]                     k_r, k_nxt;
  logic [fcfe_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [fcfe_pkg::FACE_W-1:0]    face;
  logic                           face_done, cell_done, load;

  // lowest pending face goes first
  always_comb begin
    face = '0;
    for (int f = fcfe_pkg::NUM_FACES - 1; f >= 0; f--) begin
      if (mask_r[f]) face = fcfe_pkg::FACE_W'(f);
    end
  end

  assign face_done = (k_r == fcfe_pkg::VTX_LAST);
  assign mask_left = face_done ? (mask_r & ~(fcfe_pkg::face_mask_t'(1) << face)) : mask_r;
  assign cell_done = face_done && (mask_left == '0);
  assign load      = !cur_vld_r || cell_done;
  assign q_pop     = adv && load && !q_empty;

  assign job_valid = cur_vld_r;
  assign job = '{cell_x: cx_r, cell_y: cy_r, cell_z: cz_r, face: face,
                 corner_idx: k_r, vnum: cnt_r, last: cell_done};

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    cz_nxt      = cz_r;
    mask_nxt    = mask_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    if (adv) begin
      if (cur_vld_r) begin
        k_nxt       = k_r + 1'b1;
        mask_nxt    = mask_left;
        cnt_nxt     = cnt_r + 1'b1;
        cur_vld_nxt = !cell_done;
      end
      if (q_pop) begin
        cx_nxt      = q_entry.cell_x;
        cy_nxt      = q_entry.cell_y;
        cz_nxt      = q_entry.cell_z;
        mask_nxt    = q_entry.faces;
        k_nxt       = '0;
        cur_vld_nxt = (q_entry.faces != '0);
        if (q_entry.new_mesh) cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      mask_r    <= '0;
      k_r       <= '0;
      cnt_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      mask_r    <= mask_nxt;
      k_r       <= k_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    cz_r <= cz_nxt;
  end

endmodule

// ----- hw/rtl/fcfe_vtx.sv -----
// Vertex datapath: corner positions, rounding, and pipelined UV division.
module fcfe_vtx (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  job_valid,
  input  fcfe_pkg::vtx_job_t                    job,
  input  logic [fcfe_pkg::SIZE_W-1:0]           sponge_size,
  input  logic [fcfe_pkg::SIZE_W-1:0]           cell_size,
  output logic                                  adv,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [fcfe_pkg::POS_W-1:0]     out_pos_x,
  output logic signed [fcfe_pkg::POS_W-1:0]     out_pos_y,
  output logic signed [fcfe_pkg::POS_W-1:0]     out_pos_z,
  output logic [fcfe_pkg::UV_W-1:0]             out_tex_u,
  output logic [fcfe_pkg::UV_W-1:0]             out_tex_v,
  output logic [fcfe_pkg::FACE_W-1:0]           out_face_dir,
  output logic [fcfe_pkg::CNT_W-1:0]            out_vertex_number,
  output logic                                  out_last_vertex
);

  localparam int DIV_STEPS = fcfe_pkg::UV_W;

  typedef logic signed [fcfe_pkg::P2_W-1:0] p2_t;

  typedef struct packed {
    logic [fcfe_pkg::DIV_W-1:0] rem;
    logic [fcfe_pkg::UV_W-1:0]  lo;
    logic [fcfe_pkg::UV_W-1:0]  q;
  } div_lane_t;

  typedef struct packed {
    logic [fcfe_pkg::POS_W-1:0]  pos_x;
    logic [fcfe_pkg::POS_W-1:0]  pos_y;
    logic [fcfe_pkg::POS_W-1:0]  pos_z;
    logic [fcfe_pkg::FACE_W-1:0] face;
    logic [fcfe_pkg::CNT_W-1:0]  vnum;
    logic                        last;
    logic                        u_zero;
    logic                        u_full;
    logic                        v_zero;
    logic                        v_full;
    div_lane_t                   u;
    div_lane_t                   v;
  } div_stage_t;

  // round half up, then clamp to the position range
  function automatic logic [fcfe_pkg::POS_W-1:0] pos_round(p2_t p2);
    p2_t r;
    r = (p2 + signed'(fcfe_pkg::P2_W'(1))) >>> 1;
    if (r > fcfe_pkg::POS_LIM) r = fcfe_pkg::POS_LIM;
    if (r < fcfe_pkg::NEG_LIM) r = fcfe_pkg::NEG_LIM;
    return r[fcfe_pkg::POS_W-1:0];
  endfunction

  // restoring division, one quotient bit per stage
  function automatic div_lane_t div_step(div_lane_t l, logic [fcfe_pkg::DIV_W-1:0] d);
    logic [fcfe_pkg::DIV_W:0] t;
    div_lane_t o;
    t    = {l.rem, l.lo[fcfe_pkg::UV_W-1]};
    o.lo = {l.lo[fcfe_pkg::UV_W-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      o.rem = fcfe_pkg::DIV_W'(t - {1'b0, d});
      o.q   = {l.q[fcfe_pkg::UV_W-2:0], 1'b1};
    end else begin
      o.rem = t[fcfe_pkg::DIV_W-1:0];
      o.q   = {l.q[fcfe_pkg::UV_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [2:0]                   corner;
  logic [fcfe_pkg::NBR_W-1:0]   ix, iy, iz;
  logic [fcfe_pkg::MUL_W-1:0]   mul_x, mul_y, mul_z;
  p2_t                          s_ext, d_ext;
  logic [fcfe_pkg::DIV_W-1:0]   divisor;

  logic                         a_vld_r;
  p2_t                          a_px_r, a_py_r, a_pz_r;
  logic [fcfe_pkg::FACE_W-1:0]  a_face_r;
  logic [fcfe_pkg::CNT_W-1:0]   a_vnum_r;
  logic                         a_last_r;

  p2_t                          au, av;
  logic [fcfe_pkg::NUM_W-1:0]   num_u, num_v;
  div_stage_t                   b_nxt;

  div_stage_t                   dv_r   [DIV_STEPS+1];
  div_stage_t                   dv_nxt [DIV_STEPS+1];
  logic [DIV_STEPS:0]           dv_vld_r;

  logic                         out_valid_r;
  div_stage_t                   tail;

  assign adv       = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;

  assign s_ext   = signed'(fcfe_pkg::P2_W'(sponge_size));
  assign d_ext   = signed'(fcfe_pkg::P2_W'({sponge_size, 1'b0}));
  assign divisor = {sponge_size, 1'b0};

  // stage A: corner index times cell edge, doubled, minus sponge edge
  assign corner = fcfe_pkg::corner_code(job.face, job.corner_idx);
  assign ix     = fcfe_pkg::NBR_W'(job.cell_x) + fcfe_pkg::NBR_W'(corner[0]);
  assign iy     = fcfe_pkg::NBR_W'(job.cell_y) + fcfe_pkg::NBR_W'(corner[1]);
  assign iz     = fcfe_pkg::NBR_W'(job.cell_z) + fcfe_pkg::NBR_W'(corner[2]);
  assign mul_x  = fcfe_pkg::MUL_W'(ix) * fcfe_pkg::MUL_W'(cell_size);
  assign mul_y  = fcfe_pkg::MUL_W'(iy) * fcfe_pkg::MUL_W'(cell_size);
  assign mul_z  = fcfe_pkg::MUL_W'(iz) * fcfe_pkg::MUL_W'(cell_size);

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= job_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_px_r   <= {1'b0, mul_x, 1'b0} - s_ext;
      a_py_r   <= {1'b0, mul_y, 1'b0} - s_ext;
      a_pz_r   <= {1'b0, mul_z, 1'b0} - s_ext;
      a_face_r <= job.face;
      a_vnum_r <= job.vnum;
      a_last_r <= job.last;
    end
  end

  // stage B: UV numerators per face, range flags, divider seed
  always_comb begin
    case (a_face_r)
      fcfe_pkg::FACE_PX: begin au = s_ext - a_py_r;  av = s_ext - a_pz_r;  end
      fcfe_pkg::FACE_NX: begin au = a_py_r + s_ext;  av = s_ext - a_pz_r;  end
      fcfe_pkg::FACE_PY: begin au = a_px_r + s_ext;  av = s_ext - a_pz_r;  end
      fcfe_pkg::FACE_NY: begin au = s_ext - a_px_r;  av = s_ext - a_pz_r;  end
      fcfe_pkg::FACE_PZ: begin au = a_py_r + s_ext;  av = s_ext - a_px_r;  end
      fcfe_pkg::FACE_NZ: begin au = a_py_r + s_ext;  av = a_px_r + s_ext;  end
      default:           begin au = '0;              av = '0;              end
    endcase
  end

  // a * 2^16 + S; only meaningful when 0 < a < 2S
  assign num_u = fcfe_pkg::NUM_W'({au[fcfe_pkg::DIV_W-1:0], 16'd0}) +
                 fcfe_pkg::NUM_W'(sponge_size);
  assign num_v = fcfe_pkg::NUM_W'({av[fcfe_pkg::DIV_W-1:0], 16'd0}) +
                 fcfe_pkg::NUM_W'(sponge_size);

  always_comb begin
    b_nxt.pos_x  = pos_round(a_px_r);
    b_nxt.pos_y  = pos_round(a_py_r);
    b_nxt.pos_z  = pos_round(a_pz_r);
    b_nxt.face   = a_face_r;
    b_nxt.vnum   = a_vnum_r;
    b_nxt.last   = a_last_r;
    b_nxt.u_zero = (sponge_size == '0) || (au <= signed'(fcfe_pkg::P2_W'(0)));
    b_nxt.u_full = (au >= d_ext);
    b_nxt.v_zero = (sponge_size == '0) || (av <= signed'(fcfe_pkg::P2_W'(0)));
    b_nxt.v_full = (av >= d_ext);
    b_nxt.u.rem  = num_u[fcfe_pkg::NUM_W-1:fcfe_pkg::UV_W];
    b_nxt.u.lo   = num_u[fcfe_pkg::UV_W-1:0];
    b_nxt.u.q    = '0;
    b_nxt.v.rem  = num_v[fcfe_pkg::NUM_W-1:fcfe_pkg::UV_W];
    b_nxt.v.lo   = num_v[fcfe_pkg::UV_W-1:0];
    b_nxt.v.q    = '0;
  end

  always_comb begin
    dv_nxt[0] = b_nxt;
    for (int j = 1; j <= DIV_STEPS; j++) begin
      dv_nxt[j]   = dv_r[j-1];
      dv_nxt[j].u = div_step(dv_r[j-1].u, divisor);
      dv_nxt[j].v = div_step(dv_r[j-1].v, divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r <= '0;
    else if (adv) dv_vld_r <= {dv_vld_r[DIV_STEPS-1:0], a_vld_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j <= DIV_STEPS; j++) dv_r[j] <= dv_nxt[j];
    end
  end

  // output register
  assign tail = dv_r[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_vld_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_x         <= signed'(tail.pos_x);
      out_pos_y         <= signed'(tail.pos_y);
      out_pos_z         <= signed'(tail.pos_z);
      out_tex_u         <= tail.u_zero ? '0 : (tail.u_full ? fcfe_pkg::UV_ONE : tail.u.q);
      out_tex_v         <= tail.v_zero ? '0 : (tail.v_full ? fcfe_pkg::UV_ONE : tail.v.q);
      out_face_dir      <= tail.face;
      out_vertex_number <= tail.vnum;
      out_last_vertex   <= tail.last;
    end
  end

endmodule
